// File: hw/rtl/asm_pkg.sv
// ============================================================================
// asm_pkg: shared types, signature tables and helpers
// Holds the signature alternatives of the four attack classes, packed as
// element strings, together with byte folding and element matching helpers.
// ============================================================================
package asm_pkg;

    localparam int unsigned NumClasses = 4;
    localparam int unsigned NumAlts    = 24;
    localparam int unsigned MaxLen     = 12;

    // Special element codes inside a signature string.
    localparam logic [7:0] ElSpace = 8'h01;   // any white-space byte
    localparam logic [7:0] ElNotGt = 8'h02;   // any byte except '>'

    typedef enum logic [1:0] {
        CLS_SQLI      = 2'd0,
        CLS_XSS       = 2'd1,
        CLS_TRAVERSAL = 2'd2,
        CLS_SCANNER   = 2'd3
    } t_rule_class;

    // Control request from the top level to the matcher core.
    typedef struct packed {
        logic step;    // process the staged item in this cycle
        logic has;     // the staged item carries a byte
        logic last;    // the staged item closes the text
    } t_nfa_ctl;

    // Signature strings, element 0 is the leftmost character.
    localparam logic [8*MaxLen-1:0] AltStr [NumAlts] = '{
        "union\001select",
        "or\0011\001=\0011",
        "';",
        "--\001",
        "/*",
        "sleep\001(",
        "benchmark\001(",
        "<script",
        "javascript:",
        "onerror\001=",
        "onload\001=",
        "<img\002src",
        "../",
        "..\\",
        "%2e%2e/",
        "/etc/passwd",
        "c:\\windows",
        "sqlmap",
        "nikto",
        "nmap",
        "masscan",
        "acunetix",
        "nessus",
        "zgrab"
    };

    localparam int unsigned AltLen [NumAlts] = '{
        12, 8, 2, 3, 2, 7, 11,
        7, 11, 9, 8, 8,
        3, 3, 7, 11, 10,
        6, 5, 4, 7, 8, 6, 5
    };

    localparam t_rule_class AltCls [NumAlts] = '{
        CLS_SQLI, CLS_SQLI, CLS_SQLI, CLS_SQLI, CLS_SQLI, CLS_SQLI, CLS_SQLI,
        CLS_XSS, CLS_XSS, CLS_XSS, CLS_XSS, CLS_XSS,
        CLS_TRAVERSAL, CLS_TRAVERSAL, CLS_TRAVERSAL, CLS_TRAVERSAL, CLS_TRAVERSAL,
        CLS_SCANNER, CLS_SCANNER, CLS_SCANNER, CLS_SCANNER, CLS_SCANNER,
        CLS_SCANNER, CLS_SCANNER
    };

    // Bit k marks element k as repeated one or more times.
    localparam logic [MaxLen-1:0] AltPlus [NumAlts] = '{
        12'h020, 12'h004, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h010,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
    };

    // Bit k marks element k as repeated zero or more times.
    localparam logic [MaxLen-1:0] AltStar [NumAlts] = '{
        12'h000, 12'h050, 12'h000, 12'h000, 12'h000, 12'h020, 12'h200,
        12'h000, 12'h000, 12'h080, 12'h040, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
        12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000
    };

    // Fold upper-case ASCII letters to lower case.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // True if one signature element accepts the folded byte.
    function automatic logic elem_match(input logic [7:0] el, input logic [7:0] c);
        logic r;
        if (el == ElSpace) begin
            r = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        end else if (el == ElNotGt) begin
            r = (c != 8'h3E);
        end else begin
            r = (c == el);
        end
        return r;
    endfunction

    // Lowest-numbered class whose matched bit is set, sqli when none is.
    function automatic t_rule_class lowest_class(input logic [NumClasses-1:0] m);
        t_rule_class r;
        if (m[0]) begin
            r = CLS_SQLI;
        end else if (m[1]) begin
            r = CLS_XSS;
        end else if (m[2]) begin
            r = CLS_TRAVERSAL;
        end else if (m[3]) begin
            r = CLS_SCANNER;
        end else begin
            r = CLS_SQLI;
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/asm_nfa.sv
// ============================================================================
// asm_nfa: bit-parallel signature automata
// Keeps one active bit per signature element and the sticky matched flags
// of the four classes; advances all alternatives by one byte per request.
// ============================================================================
module asm_nfa (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  asm_pkg::t_nfa_ctl                 i_ctl,
    input  logic [7:0]                        i_byte,
    output logic [asm_pkg::NumClasses-1:0]    o_matched
);
    import asm_pkg::*;

    logic [MaxLen-1:0]     r_active [NumAlts];
    logic [MaxLen-1:0]     n_active [NumAlts];
    logic [NumClasses-1:0] r_matched;
    logic [NumAlts-1:0]    w_alt_acc;
    logic [NumClasses-1:0] w_cls_acc;
    logic [7:0]            w_c;

    assign w_c = fold_byte(i_byte);

    // One chain per alternative: reach is the position before an element in
    // the old state, acc the position after it in the new state.
    for (genvar a = 0; a < NumAlts; a++) begin : g_alt
        logic [MaxLen:0]   w_reach;
        logic [MaxLen:0]   w_acc;
        logic [MaxLen-1:0] w_new;

        assign w_reach[0] = 1'b1;
        assign w_acc[0]   = 1'b0;

        for (genvar k = 0; k < MaxLen; k++) begin : g_el
            if (k < AltLen[a]) begin : g_used
                localparam logic [7:0] El = AltStr[a][8*(AltLen[a]-1-k) +: 8];
                assign w_new[k] = elem_match(El, w_c)
                    && (w_reach[k] || ((AltPlus[a][k] || AltStar[a][k])
                                       && r_active[a][k]));
                assign w_reach[k+1] = r_active[a][k] || (AltStar[a][k] && w_reach[k]);
                assign w_acc[k+1]   = w_new[k] || (AltStar[a][k] && w_acc[k]);
            end else begin : g_unused
                assign w_new[k]     = 1'b0;
                assign w_reach[k+1] = 1'b0;
                assign w_acc[k+1]   = 1'b0;
            end
        end

        assign n_active[a]  = w_new;
        assign w_alt_acc[a] = w_acc[AltLen[a]];
    end

    // Collect alternative accepts into their classes.
    always_comb begin
        w_cls_acc = '0;
        for (int a = 0; a < NumAlts; a++) begin
            if (w_alt_acc[a]) begin
                w_cls_acc[AltCls[a]] = 1'b1;
            end
        end
    end

    // Matched flags including the byte under work.
    assign o_matched = r_matched | (i_ctl.has ? w_cls_acc : '0);

    // State update; the closing item clears everything for the next text.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matched <= '0;
            for (int a = 0; a < NumAlts; a++) begin
                r_active[a] <= '0;
            end
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                r_matched <= '0;
                for (int a = 0; a < NumAlts; a++) begin
                    r_active[a] <= '0;
                end
            end else if (i_ctl.has) begin
                r_matched <= o_matched;
                for (int a = 0; a < NumAlts; a++) begin
                    r_active[a] <= n_active[a];
                end
            end
        end
    end

endmodule

// File: hw/rtl/attack_signature_matcher.sv
// ============================================================================
// attack_signature_matcher: streaming attack signature search
// Searches one text for sqli, xss, traversal and scanner signatures and
// reports the lowest-numbered class found when the text closes.
// ============================================================================
// Channel    Direction  tdata                 tuser        tlast
// s_axis     in         [7:0] text_byte       [0] has_byte end_of_text
// m_axis     out        [1:0] rule_class      [0] hit      -
//
// One item is taken per cycle, but a stalled result holds back a closing
// item in the input register and the requests behind it; byte items ahead
// of that item keep flowing. A staged byte item is processed in the next
// cycle, a closing item once the result register is free. The automata
// update is the single combinational step between those registers. Reset
// is synchronous and clears the valid flags and automata state.
// ============================================================================
module attack_signature_matcher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] text_byte
    input  logic       i_s_axis_tuser,   // [0] has_byte
    input  logic       i_s_axis_tlast,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [1:0] rule_class, [7:2] zero
    output logic       o_m_axis_tuser,   // [0] hit
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready
);
    import asm_pkg::*;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_has;
    logic                  r_in_last;
    logic                  r_out_valid;
    logic                  r_out_hit;
    t_rule_class           r_out_cls;
    logic                  w_take;
    logic                  w_out_free;
    t_nfa_ctl              w_ctl;
    logic [NumClasses-1:0] w_matched;

    // Handshake control: a closing item waits for room in the output register.
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_ctl.step      = r_in_valid && (!r_in_last || w_out_free);
    assign w_ctl.has       = r_in_has;
    assign w_ctl.last      = r_in_last;
    assign o_s_axis_tready = !r_in_valid || w_ctl.step;
    assign w_take          = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_ctl.step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_has  <= i_s_axis_tuser;
            r_in_last <= i_s_axis_tlast;
        end
    end

    asm_nfa u_nfa (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_byte    (r_in_byte),
        .o_matched (w_matched)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.step && r_in_last) begin
            r_out_hit <= |w_matched;
            r_out_cls <= lowest_class(w_matched);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_hit;
    assign o_m_axis_tdata  = {6'b0, r_out_cls};

endmodule

// File: hw/rtl/asm_checker.sv
// ============================================================================
// asm_checker: port-level checks for the signature matcher
// Watches the top-level ports only and is attached by a bind statement.
// ============================================================================
module asm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready
);

    // No result request is pending right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result request keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // Without a hit the class field reads zero.
    a_no_hit_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> o_m_axis_tdata[1:0] == 2'd0)
        else $error("class set without hit");

    // Padding bits of the result stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[7:2] == 6'd0)
        else $error("result padding not zero");

    // The input side cannot be stalled while no result is waiting.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid && $past(!o_m_axis_tvalid) && $past(i_rst_n)
            |-> o_s_axis_tready)
        else $error("input stalled with no result pending");

endmodule

bind attack_signature_matcher asm_checker u_asm_checker (.*);
